// ===== rtl/rta_pkg.sv =====
// ----------------------------------------------------------------------------
// rta_pkg: shared types and constants of the request tag allocator
// Command, status and tag phase codes, and the fixed widths of the
// transaction fields.
// ----------------------------------------------------------------------------
package rta_pkg;

	localparam int TAGS_DEF    = 64;
	localparam int TAG_FIELD_W = 6;
	localparam int DEPTH_W     = 7;
	localparam int SEQ_W       = 64;

	typedef enum logic [1:0] {
		CMD_PUSH            = 2'd0,
		CMD_TAKE            = 2'd1,
		CMD_RELEASE         = 2'd2,
		CMD_RELEASE_PENDING = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_FREE      = 2'd1,
		ST_NONE_PENDING = 2'd2,
		ST_BAD_TAG      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_FREE    = 2'd0,
		PH_PENDING = 2'd1,
		PH_TAKEN   = 2'd2
	} phase_t;

endpackage

// ===== rtl/rta_if.sv =====
// ----------------------------------------------------------------------------
// rta_if: channel interfaces of the request tag allocator
// Command channel and response channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface rta_req_if;
	logic                               valid;
	logic                               ready;
	rta_pkg::command_t                  command;
	logic [rta_pkg::TAG_FIELD_W-1:0]    tag;

	modport source (output valid, output command, output tag, input ready);
	modport sink   (input valid, input command, input tag, output ready);
endinterface

interface rta_rsp_if;
	logic                               valid;
	logic                               ready;
	rta_pkg::status_t                   status;
	logic [rta_pkg::TAG_FIELD_W-1:0]    result_tag;
	logic [rta_pkg::SEQ_W-1:0]          sequence_res;
	logic [rta_pkg::DEPTH_W-1:0]        depth;

	modport source (output valid, output status, output result_tag, output sequence_res,
		output depth, input ready);
	modport sink   (input valid, input status, input result_tag, input sequence_res,
		input depth, output ready);
endinterface

// ===== rtl/request_tag_allocator.sv =====
// ----------------------------------------------------------------------------
// request_tag_allocator: tag pool with a pending queue
// Free tags sit in a ring memory; pending tags form a doubly linked list held
// in a per-tag memory together with each tag's phase.
// ----------------------------------------------------------------------------
//
//  channel | role | payload                                       | handshake
//  --------+------+-----------------------------------------------+-----------
//  req     | sink | command, tag                                  | valid/ready
//  rsp     | src  | status, result_tag, sequence_res, depth       | valid/ready
//
// One transaction at a time; the single write port of the tag memory splits
// each into steps. Push writes the new entry, links it behind the tail if the
// pending list holds a tag; take marks the head taken; release checks the
// phase and frees the tag; pending release also mends the neighbours' links.
// Errors other than a wrong phase go straight to the finishing step. After
// reset a clearing pass seeds both memories; req.ready stays low meanwhile.
// A response waiting on rsp.ready blocks no accept, only the next finishing step.
// ----------------------------------------------------------------------------
module request_tag_allocator #(
	parameter int TAGS = rta_pkg::TAGS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rta_req_if.sink   req,
	rta_rsp_if.source rsp
);

	localparam int TAG_W = $clog2(TAGS);
	localparam int CNT_W = $clog2(TAGS + 1);
	localparam int TF_W  = rta_pkg::TAG_FIELD_W;
	localparam int DP_W  = rta_pkg::DEPTH_W;
	localparam int SQ_W  = rta_pkg::SEQ_W;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_PUSH_WR,
		S_PUSH_LINK,
		S_TAKE_WR,
		S_CHECK,
		S_FIX_NEXT,
		S_FIX_PREV,
		S_DONE
	} state_t;

	typedef struct packed {
		rta_pkg::phase_t    phase;
		logic [TAG_W-1:0]   nxt;
		logic [TAG_W-1:0]   prv;
	} entry_t;

	typedef struct packed {
		logic phase;
		logic nxt;
		logic prv;
	} wmask_t;

	// memories
	entry_t             tag_mem [TAGS];
	logic [TAG_W-1:0]   free_ring [TAGS];

	entry_t             ent_rd_s1;
	logic [TAG_W-1:0]   ring_rd_s1;

	// control and pointers
	state_t             state_q;
	logic [TAG_W-1:0]   init_idx_q;
	rta_pkg::command_t  cmd_q;
	logic [TAG_W-1:0]   tag_q;
	logic [TAG_W-1:0]   free_head_q;
	logic [CNT_W-1:0]   free_count_q;
	logic [TAG_W-1:0]   pend_head_q;
	logic [TAG_W-1:0]   pend_tail_q;
	logic [CNT_W-1:0]   pend_count_q;
	logic [SQ_W-1:0]    next_seq_q;
	logic [TAG_W-1:0]   p_q;
	logic [TAG_W-1:0]   n_q;
	logic               fix_next_q;
	logic               fix_prev_q;

	// staged response and output register
	rta_pkg::status_t   res_status_q;
	logic [TF_W-1:0]    res_tag_q;
	logic [SQ_W-1:0]    res_seq_q;
	logic               rsp_valid_q;
	rta_pkg::status_t   rsp_status_q;
	logic [TF_W-1:0]    rsp_tag_q;
	logic [SQ_W-1:0]    rsp_seq_q;
	logic [DP_W-1:0]    rsp_depth_q;

	// combinational
	logic [TAG_W-1:0]   req_idx;
	logic               req_in_range;
	logic [TAG_W-1:0]   tm_raddr;
	logic               tm_we;
	logic [TAG_W-1:0]   tm_waddr;
	entry_t             tm_wdata;
	wmask_t             tm_wmask;
	logic               fr_we;
	logic [TAG_W-1:0]   fr_waddr;
	logic [TAG_W-1:0]   fr_wdata;
	logic [CNT_W:0]     slot_sum;
	logic [TAG_W-1:0]   free_slot;
	logic [TAG_W-1:0]   free_head_nx;
	logic               release_ok;
	logic               out_free;

	assign req_idx      = TAG_W'(req.tag);
	assign req_in_range = 32'(req.tag) < TAGS;
	assign tm_raddr     = (req.command == rta_pkg::CMD_TAKE) ? pend_head_q : req_idx;

	assign slot_sum     = (CNT_W+1)'(free_head_q) + (CNT_W+1)'(free_count_q);
	assign free_slot    = (slot_sum >= (CNT_W+1)'(TAGS)) ?
		TAG_W'(slot_sum - (CNT_W+1)'(TAGS)) : TAG_W'(slot_sum);
	assign free_head_nx = (free_head_q == TAG_W'(TAGS - 1)) ? '0 : free_head_q + 1'b1;

	assign release_ok =
		((cmd_q == rta_pkg::CMD_RELEASE) && (ent_rd_s1.phase == rta_pkg::PH_TAKEN)) ||
		((cmd_q == rta_pkg::CMD_RELEASE_PENDING) && (ent_rd_s1.phase == rta_pkg::PH_PENDING));

	assign out_free = !rsp_valid_q || rsp.ready;

	// write port steering for both memories
	always_comb begin
		tm_we    = 1'b0;
		tm_waddr = tag_q;
		tm_wdata = '0;
		tm_wmask = '0;
		fr_we    = 1'b0;
		fr_waddr = free_slot;
		fr_wdata = tag_q;
		unique case (state_q)
			S_INIT: begin
				tm_we          = 1'b1;
				tm_waddr       = init_idx_q;
				tm_wdata.phase = rta_pkg::PH_FREE;
				tm_wmask       = '1;
				fr_we          = 1'b1;
				fr_waddr       = init_idx_q;
				fr_wdata       = init_idx_q;
			end
			S_PUSH_WR: begin
				tm_we          = 1'b1;
				tm_waddr       = ring_rd_s1;
				tm_wdata.phase = rta_pkg::PH_PENDING;
				tm_wdata.prv   = pend_tail_q;
				tm_wmask.phase = 1'b1;
				tm_wmask.prv   = 1'b1;
			end
			S_PUSH_LINK: begin
				tm_we          = 1'b1;
				tm_waddr       = pend_tail_q;
				tm_wdata.nxt   = tag_q;
				tm_wmask.nxt   = 1'b1;
			end
			S_TAKE_WR: begin
				tm_we          = 1'b1;
				tm_wdata.phase = rta_pkg::PH_TAKEN;
				tm_wmask.phase = 1'b1;
			end
			S_CHECK: begin
				tm_we          = release_ok;
				tm_wdata.phase = rta_pkg::PH_FREE;
				tm_wmask.phase = 1'b1;
				fr_we          = release_ok;
			end
			S_FIX_NEXT: begin
				tm_we          = fix_next_q;
				tm_waddr       = p_q;
				tm_wdata.nxt   = n_q;
				tm_wmask.nxt   = 1'b1;
			end
			S_FIX_PREV: begin
				tm_we          = fix_prev_q;
				tm_waddr       = n_q;
				tm_wdata.prv   = p_q;
				tm_wmask.prv   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tm_we) begin
			if (tm_wmask.phase) tag_mem[tm_waddr].phase <= tm_wdata.phase;
			if (tm_wmask.nxt)   tag_mem[tm_waddr].nxt   <= tm_wdata.nxt;
			if (tm_wmask.prv)   tag_mem[tm_waddr].prv   <= tm_wdata.prv;
		end
		ent_rd_s1 <= tag_mem[tm_raddr];
	end

	always_ff @(posedge clk) begin
		if (fr_we) begin
			free_ring[fr_waddr] <= fr_wdata;
		end
		ring_rd_s1 <= free_ring[free_head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			init_idx_q   <= '0;
			cmd_q        <= rta_pkg::CMD_PUSH;
			tag_q        <= '0;
			free_head_q  <= '0;
			free_count_q <= CNT_W'(TAGS);
			pend_head_q  <= '0;
			pend_tail_q  <= '0;
			pend_count_q <= '0;
			next_seq_q   <= '0;
			p_q          <= '0;
			n_q          <= '0;
			fix_next_q   <= 1'b0;
			fix_prev_q   <= 1'b0;
			res_status_q <= rta_pkg::ST_OK;
			res_tag_q    <= '0;
			res_seq_q    <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= rta_pkg::ST_OK;
			rsp_tag_q    <= '0;
			rsp_seq_q    <= '0;
			rsp_depth_q  <= '0;
		end else begin
			// the finishing step reloads the output register itself
			if (rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					init_idx_q <= init_idx_q + 1'b1;
					if (init_idx_q == TAG_W'(TAGS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						cmd_q        <= req.command;
						tag_q        <= req_idx;
						res_status_q <= rta_pkg::ST_OK;
						res_tag_q    <= '0;
						res_seq_q    <= '0;
						unique case (req.command)
							rta_pkg::CMD_PUSH: begin
								if (free_count_q == '0) begin
									res_status_q <= rta_pkg::ST_NO_FREE;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_PUSH_WR;
								end
							end
							rta_pkg::CMD_TAKE: begin
								tag_q <= pend_head_q;
								if (pend_count_q == '0) begin
									res_status_q <= rta_pkg::ST_NONE_PENDING;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_TAKE_WR;
								end
							end
							rta_pkg::CMD_RELEASE, rta_pkg::CMD_RELEASE_PENDING: begin
								if (!req_in_range) begin
									res_status_q <= rta_pkg::ST_BAD_TAG;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_CHECK;
								end
							end
						endcase
					end
				end
				S_PUSH_WR: begin
					tag_q        <= ring_rd_s1;
					res_tag_q    <= TF_W'(ring_rd_s1);
					res_seq_q    <= next_seq_q;
					next_seq_q   <= next_seq_q + 1'b1;
					free_head_q  <= free_head_nx;
					free_count_q <= free_count_q - 1'b1;
					if (pend_count_q == '0) begin
						pend_head_q  <= ring_rd_s1;
						pend_tail_q  <= ring_rd_s1;
						pend_count_q <= pend_count_q + 1'b1;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_PUSH_LINK;
					end
				end
				S_PUSH_LINK: begin
					pend_tail_q  <= tag_q;
					pend_count_q <= pend_count_q + 1'b1;
					state_q      <= S_DONE;
				end
				S_TAKE_WR: begin
					res_tag_q    <= TF_W'(tag_q);
					pend_count_q <= pend_count_q - 1'b1;
					// last one out: list pointers return to zero
					if (pend_count_q == CNT_W'(1)) begin
						pend_head_q <= '0;
						pend_tail_q <= '0;
					end else begin
						pend_head_q <= ent_rd_s1.nxt;
					end
					state_q <= S_DONE;
				end
				S_CHECK: begin
					if (!release_ok) begin
						res_status_q <= rta_pkg::ST_BAD_TAG;
						state_q      <= S_DONE;
					end else begin
						free_count_q <= free_count_q + 1'b1;
						if (cmd_q == rta_pkg::CMD_RELEASE_PENDING) begin
							p_q          <= ent_rd_s1.prv;
							n_q          <= ent_rd_s1.nxt;
							fix_next_q   <= (tag_q != pend_head_q);
							fix_prev_q   <= (tag_q != pend_tail_q);
							pend_count_q <= pend_count_q - 1'b1;
							if (pend_count_q == CNT_W'(1)) begin
								pend_head_q <= '0;
								pend_tail_q <= '0;
							end else begin
								if (tag_q == pend_head_q) pend_head_q <= ent_rd_s1.nxt;
								if (tag_q == pend_tail_q) pend_tail_q <= ent_rd_s1.prv;
							end
							state_q <= S_FIX_NEXT;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_FIX_NEXT: begin
					state_q <= S_FIX_PREV;
				end
				S_FIX_PREV: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_tag_q    <= res_tag_q;
						rsp_seq_q    <= res_seq_q;
						rsp_depth_q  <= DP_W'(CNT_W'(TAGS) - free_count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.result_tag   = rsp_tag_q;
	assign rsp.sequence_res = rsp_seq_q;
	assign rsp.depth        = rsp_depth_q;

`ifndef SYNTH
	a_counts_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(free_count_q) + 32'(pend_count_q)) <= TAGS)
		else $error("free and pending counts exceed the pool");

	a_empty_list_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_count_q == '0) |-> ((pend_head_q == '0) && (pend_tail_q == '0)))
		else $error("empty pending list with non-zero pointers");

	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		(next_seq_q != $past(next_seq_q)) |-> (next_seq_q == $past(next_seq_q) + 1'b1))
		else $error("sequence number moved by other than one");

	a_seq_on_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		(next_seq_q != $past(next_seq_q)) |-> ($past(state_q) == S_PUSH_WR))
		else $error("sequence number advanced outside a push");
`endif

endmodule
